>>> src/sr2t_pkg.sv
// ----------------------------------------------------------------------------
// sr2t_pkg: shared definitions for the signed radix-to-text converter
// Widths, character codes, register indexes, state encoding and the
// alphabet lookup.
// ----------------------------------------------------------------------------
package sr2t_pkg;

    localparam int MAX_RADIX     = 16;
    localparam int VALUE_W       = 32;
    localparam int CHAR_W        = 8;
    localparam int DIGIT_W       = 4;
    localparam int NUM_SYMBOLS   = 16;
    localparam int ALPHA_W       = 64;
    localparam int ALPHA_ALL_W   = 2 * ALPHA_W;
    localparam int RADIX_W       = 5;
    localparam int CFG_ADDR_W    = 2;
    localparam int MAX_DIGITS    = 32;
    localparam int STACK_W       = MAX_DIGITS * DIGIT_W;
    localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
    localparam int BITS_PER_STEP = 4;
    localparam int STEPS         = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(STEPS);
    localparam int SYM_IDX_W     = $clog2(NUM_SYMBOLS);

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RADIX      = 2'd0,
        REG_ALPHA_LOW  = 2'd1,
        REG_ALPHA_HIGH = 2'd2
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_SIGN  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [ALPHA_ALL_W-1:0] alpha,
        input logic [SYM_IDX_W-1:0]   d
    );
        return alpha[{d, 3'b000} +: CHAR_W];
    endfunction

endpackage

>>> src/signed_radix_to_text.sv
// ----------------------------------------------------------------------------
// signed_radix_to_text: signed 32-bit integer to text in a configured radix
// Each input beat carries one integer; the block sends its text one character
// per beat: a minus sign for negative values, then the digits, most
// significant first, with tlast on the final character.
// ----------------------------------------------------------------------------
// Timing: digits are produced by a shared long divider that takes four
// dividend bits per cycle; digits are pushed on a stack of 4-bit entries
// and then sent at one character per cycle while the receiver is ready.
// After any register write the alphabet is validated, and no input beat is
// taken until the check is done. With an invalid alphabet (radix outside
// 2..16, a repeated character, a zero byte, '+' or '-') input beats are
// taken and dropped without output.
module signed_radix_to_text #(
    parameter int MAX_RADIX = sr2t_pkg::MAX_RADIX
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // value (signed)
    input  logic signed [sr2t_pkg::VALUE_W-1:0]   s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // character
    output logic [sr2t_pkg::CHAR_W-1:0]           m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_we,
    input  logic [sr2t_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [sr2t_pkg::ALPHA_W-1:0]          cfg_wdata
);
    import sr2t_pkg::*;

    state_t                   state_reg, state_next;
    logic [RADIX_W-1:0]       radix_reg, radix_next;
    logic [ALPHA_ALL_W-1:0]   alpha_reg, alpha_next;
    logic                     ok_reg, ok_next;
    logic [SYM_IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [VALUE_W-1:0]       div_reg, div_next;
    logic [DIGIT_W-1:0]       rem_reg, rem_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [STACK_W-1:0]       stack_reg, stack_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     neg_reg, neg_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]        m_char_reg, m_char_next;
    logic                     m_last_reg, m_last_next;

    logic [VALUE_W-1:0]       value_bits;
    logic [VALUE_W-1:0]       mag_in;
    logic [CHAR_W-1:0]        chk_char;
    logic                     chk_bad;
    logic                     radix_ok;
    logic [DIGIT_W-1:0]       div_rem;
    logic [BITS_PER_STEP-1:0] div_q;
    logic [VALUE_W-1:0]       div_shift;
    logic                     out_free;

    assign value_bits = s_tdata;
    assign mag_in     = value_bits[VALUE_W-1] ? (~value_bits) + 32'd1 : value_bits;
    assign radix_ok   = (radix_reg >= RADIX_W'(2)) && (radix_reg <= RADIX_W'(MAX_RADIX));
    assign out_free   = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tlast  = m_last_reg;

    // Alphabet check for one symbol in use: a zero byte, '+' or '-', or equal to any later symbol in use
    always_comb begin
        chk_char = alpha_char(alpha_reg, chk_idx_reg);
        chk_bad  = 1'b0;
        if (({1'b0, chk_idx_reg} < radix_reg) &&
            (chk_char == NUL_CHAR || chk_char == PLUS_CHAR || chk_char == MINUS_CHAR)) begin
            chk_bad = 1'b1;
        end
        for (int j = 0; j < NUM_SYMBOLS; j++) begin
            if ((RADIX_W'(j) > {1'b0, chk_idx_reg}) && (RADIX_W'(j) < radix_reg) &&
                (alpha_char(alpha_reg, SYM_IDX_W'(j)) == chk_char)) begin
                chk_bad = 1'b1;
            end
        end
    end

    // Long division by radix, four dividend bits per cycle
    always_comb begin
        logic [DIGIT_W:0] r5;
        logic [DIGIT_W:0] r5_sub;
        div_rem = rem_reg;
        div_q   = '0;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            r5     = {div_rem, div_reg[VALUE_W-1-k]};
            r5_sub = r5 - radix_reg;
            if (r5 >= radix_reg) begin
                div_rem                       = r5_sub[DIGIT_W-1:0];
                div_q[BITS_PER_STEP-1-k]      = 1'b1;
            end else begin
                div_rem = r5[DIGIT_W-1:0];
            end
        end
        div_shift = {div_reg[VALUE_W-BITS_PER_STEP-1:0], div_q};
    end

    always_comb begin
        state_next    = state_reg;
        radix_next    = radix_reg;
        alpha_next    = alpha_reg;
        ok_next       = ok_reg;
        chk_idx_next  = chk_idx_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        stack_next    = stack_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        m_tvalid_next = m_tvalid_reg;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && ok_reg) begin
                    neg_next   = value_bits[VALUE_W-1];
                    div_next   = mag_in;
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_CHECK: begin
                chk_idx_next = chk_idx_reg + SYM_IDX_W'(1);
                if (chk_bad) begin
                    ok_next = 1'b0;
                end
                if (chk_idx_reg == SYM_IDX_W'(NUM_SYMBOLS - 1)) begin
                    ok_next    = ok_reg && !chk_bad && radix_ok;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                div_next  = div_shift;
                rem_next  = div_rem;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    // push the digit; quotient stays in div_reg for the next pass
                    stack_next = {stack_reg[STACK_W-DIGIT_W-1:0], div_rem};
                    cnt_next   = cnt_reg + CNT_W'(1);
                    rem_next   = '0;
                    if (div_shift == '0 || cnt_reg == CNT_W'(MAX_DIGITS - 1)) begin
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = MINUS_CHAR;
                    m_last_next   = 1'b0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = alpha_char(alpha_reg, stack_reg[DIGIT_W-1:0]);
                    m_last_next   = (cnt_reg == CNT_W'(1));
                    stack_next    = {{DIGIT_W{1'b0}}, stack_reg[STACK_W-1:DIGIT_W]};
                    cnt_next      = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes must come only while idle (not enforced here); revalidate the alphabet after each
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_RADIX:      radix_next = cfg_wdata[RADIX_W-1:0];
                REG_ALPHA_LOW:  alpha_next[ALPHA_W-1:0] = cfg_wdata;
                REG_ALPHA_HIGH: alpha_next[ALPHA_ALL_W-1:ALPHA_W] = cfg_wdata;
                default: ;
            endcase
            state_next   = ST_CHECK;
            chk_idx_next = '0;
            ok_next      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            radix_reg    <= '0;
            alpha_reg    <= '0;
            ok_reg       <= 1'b0;
            chk_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            radix_reg    <= radix_next;
            alpha_reg    <= alpha_next;
            ok_reg       <= ok_next;
            chk_idx_reg  <= chk_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        stack_reg  <= stack_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for signed_radix_to_text
// Drives signed integers into the input stream under a series of alphabet
// settings (valid, invalid and edge-case ones), predicts the character
// stream of each number and compares every output beat in order.
// ----------------------------------------------------------------------------
module testbench;
    import sr2t_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_NONE = 2'd3;  // unmapped register index
    localparam int DRAIN_CYCLES = 320;
    localparam int RANDOM_ITEMS = 310;
    localparam logic [ALPHA_ALL_W-1:0] HEX_ALPHA = 128'h46454443424139383736353433323130;
    // "01" followed by bytes that must be ignored
    localparam logic [ALPHA_ALL_W-1:0] BIN_ALPHA = 128'h0000000000000000_2D2D2D2D2D2D3130;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_beat_t;

    class text_scoreboard;
        logic [RADIX_W-1:0] radix      = '0;
        logic [ALPHA_W-1:0] alpha_low  = '0;
        logic [ALPHA_W-1:0] alpha_high = '0;
        char_beat_t         expected_chars[$];
        int                 errors     = 0;

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [ALPHA_W-1:0] data);
            case (addr)
                REG_RADIX:      radix = data[RADIX_W-1:0];
                REG_ALPHA_LOW:  alpha_low = data;
                REG_ALPHA_HIGH: alpha_high = data;
                default: ;
            endcase
        endfunction

        function logic [CHAR_W-1:0] digit_char(int d);
            if (d < 8)
                return alpha_low[8*d +: CHAR_W];
            return alpha_high[8*(d-8) +: CHAR_W];
        endfunction

        function bit alphabet_valid();
            logic [CHAR_W-1:0] c;
            if (radix < 2 || radix > MAX_RADIX)
                return 0;
            for (int i = 0; i < radix; i++) begin
                c = digit_char(i);
                if (c == NUL_CHAR || c == PLUS_CHAR || c == MINUS_CHAR)
                    return 0;
                for (int j = i + 1; j < radix; j++)
                    if (digit_char(j) == c)
                        return 0;
            end
            return 1;
        endfunction

        // Push the character beats that one accepted value produces.
        function void note_value(logic signed [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] mag;
            logic [VALUE_W-1:0] base;
            int                 digits[$];
            if (!alphabet_valid())
                return;
            base = VALUE_W'(radix);
            mag  = value[VALUE_W-1] ? (32'd0 - value) : value;
            do begin
                digits.push_back(mag % base);
                mag = mag / base;
            end while (mag != 0);
            if (value[VALUE_W-1])
                expected_chars.push_back('{ch: MINUS_CHAR, last: 1'b0});
            for (int i = digits.size() - 1; i >= 0; i--)
                expected_chars.push_back('{ch: digit_char(digits[i]), last: (i == 0)});
        endfunction

        function void check_beat(logic [CHAR_W-1:0] ch, logic last);
            char_beat_t want;
            if (expected_chars.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: unexpected beat char %h last %b", ch, last);
                return;
            end
            want = expected_chars.pop_front();
            if (want.ch !== ch || want.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected char %h last %b, got char %h last %b",
                             want.ch, want.last, ch, last);
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic signed [VALUE_W-1:0] s_tdata;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [CHAR_W-1:0]         m_tdata;
    logic                      m_tlast;
    logic                      m_tvalid;
    logic                      m_tready;
    logic                      cfg_we;
    logic [CFG_ADDR_W-1:0]     cfg_addr;
    logic [ALPHA_W-1:0]        cfg_wdata;

    text_scoreboard sb = new();
    bit             steady = 0;   // no idling on either side while set

    signed_radix_to_text i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #8000000;
        $display("FAIL");
        $finish;
    end

    // Receiver: random stalls per beat, check every accepted character.
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_beat(m_tdata, m_tlast);
        end
    end

    task automatic send_value(input logic signed [VALUE_W-1:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_value(value);
    endtask

    // Drop valid and hold until every predicted character has come out.
    task automatic hold_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] addr, input logic [ALPHA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        sb.write_reg(addr, data);
    endtask

    // Wait for the block to go quiet, then load radix and alphabet.
    task automatic apply_setting(input logic [RADIX_W-1:0] radix,
                                 input logic [ALPHA_ALL_W-1:0] alpha);
        logic [ALPHA_W-1:0] noise;
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        noise = {$urandom, $urandom};
        write_cfg(REG_RADIX, {noise[ALPHA_W-1:RADIX_W], radix});
        write_cfg(REG_ALPHA_LOW, alpha[ALPHA_W-1:0]);
        write_cfg(REG_ALPHA_HIGH, alpha[ALPHA_ALL_W-1:ALPHA_W]);
        @(negedge aclk);
        cfg_we <= 1'b0;
        steady = ($urandom_range(0, 3) == 0);
    endtask

    // First radix characters distinct and legal, the rest arbitrary bytes.
    function automatic logic [ALPHA_ALL_W-1:0] build_alphabet(input int radix);
        logic [ALPHA_ALL_W-1:0] alpha;
        bit                     taken[256];
        int                     c;
        int                     k;
        for (k = 0; k < NUM_SYMBOLS; k++) begin
            if (k < radix) begin
                do c = $urandom_range(1, 255);
                while (taken[c] || c == MINUS_CHAR || c == PLUS_CHAR);
                taken[c] = 1;
                alpha[8*k +: CHAR_W] = CHAR_W'(c);
            end else begin
                alpha[8*k +: CHAR_W] = CHAR_W'($urandom_range(0, 255));
            end
        end
        return alpha;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        int                 sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            v = $urandom;
        end else if (sel < 60) begin
            v = $urandom_range(0, 300);
        end else if (sel < 75) begin
            case ($urandom_range(0, 4))
                0: v = 32'h0000_0000;
                1: v = 32'h0000_0001;
                2: v = 32'hFFFF_FFFF;
                3: v = 32'h8000_0000;
                default: v = 32'h7FFF_FFFF;
            endcase
        end else begin
            v = $urandom >> $urandom_range(0, 31);
        end
        if (sel >= 40 && sel < 75 && $urandom_range(0, 1))
            v = 32'd0 - v;
        return v;
    endfunction

    initial begin
        logic [ALPHA_ALL_W-1:0] alpha;
        logic [RADIX_W-1:0]     radix;
        int                     valid_items;
        int                     burst;
        int                     pos;
        int                     other;
        bit                     drained_once;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Registers at reset give no usable alphabet: beats are dropped.
        send_value(32'sd0);
        send_value(-32'sd1);

        apply_setting(5'd10, HEX_ALPHA);
        send_value(32'sd0);
        send_value(32'sd1);
        send_value(-32'sd1);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'sd10);
        send_value(-32'sd987654321);

        // Base 2 gives the longest texts; bytes past the radix are junk.
        apply_setting(5'd2, BIN_ALPHA);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'sd0);
        send_value(-32'sd2);

        apply_setting(5'd16, HEX_ALPHA);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'hDEAD_BEEF);
        send_value(32'h0000_F00D);

        // A write to the unmapped index must leave the setting intact.
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_cfg(REG_NONE, {ALPHA_W{1'b1}});
        @(negedge aclk);
        cfg_we <= 1'b0;
        send_value(32'sd12345);

        // Broken alphabets: radix out of range, repeats, signs, zero byte.
        apply_setting(5'd17, HEX_ALPHA);
        send_value(32'sd77);
        apply_setting(5'd1, HEX_ALPHA);
        send_value(32'sd77);
        alpha = HEX_ALPHA;
        alpha[8*5 +: CHAR_W] = 8'h33;
        apply_setting(5'd10, alpha);
        send_value(32'sd77);
        alpha = HEX_ALPHA;
        alpha[8*4 +: CHAR_W] = PLUS_CHAR;
        apply_setting(5'd10, alpha);
        send_value(32'sd77);
        alpha = HEX_ALPHA;
        alpha[8*15 +: CHAR_W] = MINUS_CHAR;
        apply_setting(5'd16, alpha);
        send_value(-32'sd77);
        alpha = HEX_ALPHA;
        alpha[8*2 +: CHAR_W] = NUL_CHAR;
        apply_setting(5'd8, alpha);
        send_value(32'sd77);

        valid_items  = 0;
        drained_once = 0;
        while (valid_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 15) begin
                radix = RADIX_W'($urandom_range(2, 16));
                alpha = build_alphabet(radix);
                pos   = $urandom_range(0, radix - 1);
                case ($urandom_range(0, 4))
                    0: begin
                        radix = RADIX_W'($urandom_range(0, 1) ? $urandom_range(17, 31)
                                                              : $urandom_range(0, 1));
                    end
                    1: begin
                        other = $urandom_range(0, radix - 1);
                        if (other == pos)
                            other = (pos + 1) % radix;
                        alpha[8*pos +: CHAR_W] = alpha[8*other +: CHAR_W];
                    end
                    2: alpha[8*pos +: CHAR_W] = PLUS_CHAR;
                    3: alpha[8*pos +: CHAR_W] = MINUS_CHAR;
                    default: alpha[8*pos +: CHAR_W] = NUL_CHAR;
                endcase
                apply_setting(radix, alpha);
                repeat (5) send_value(pick_value());
            end else begin
                radix = RADIX_W'($urandom_range(2, 16));
                apply_setting(radix, build_alphabet(radix));
                burst = $urandom_range(10, 30);
                for (int n = 0; n < burst; n++) begin
                    // Occasionally let the output side run completely dry.
                    if (n == burst / 2 && (!drained_once || $urandom_range(0, 3) == 0)) begin
                        hold_until_drained();
                        drained_once = 1;
                    end
                    send_value(pick_value());
                    valid_items++;
                end
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
